// ----- src/tbts_pkg.sv -----
// Shared types and constants of the two-bone tube skinning block.
`timescale 1ns / 1ps

package tbts_pkg;

   localparam int unsigned POS_W  = 24;
   localparam int unsigned NRM_W  = 16;
   localparam int unsigned ROW_W  = 3 * POS_W;
   localparam int unsigned REQ_W  = 128;
   localparam int unsigned RSP_W  = 120;

   // Operation codes carried in the request tuser.
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_FIRST  = 2'd1;
   localparam logic [1:0] OP_SECOND = 2'd2;

   // Frame row that holds the segment origin.
   localparam logic [1:0] ROW_ORIGIN = 2'd3;

   typedef struct packed {
      logic [1:0]               operation;
      logic [5:0]               segment;
      logic [1:0]               row;
      logic signed [POS_W-1:0]  a_x;
      logic signed [POS_W-1:0]  a_y;
      logic signed [POS_W-1:0]  a_z;
      logic signed [NRM_W-1:0]  b_x;
      logic signed [NRM_W-1:0]  b_y;
      logic signed [NRM_W-1:0]  b_z;
   } tbts_item_type;

   typedef struct packed {
      logic       latch_in;
      logic       mem_we;
      logic       mem_re;
      logic [1:0] row;
      logic [1:0] comp;
      logic       row_latch;
      logic       mul;
      logic       acc;
      logic       fin;
      logic       org_latch;
      logic       sq;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_done;
      logic       out_load;
   } tbts_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       len_zero;
   } tbts_status_type;

endpackage

// ----- src/tbts_ctrl.sv -----
// Sequencer of the skinning block: steps the datapath through each beat's work.
`timescale 1ns / 1ps

module tbts_ctrl
   import tbts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic [1:0]      req_op,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  tbts_status_type status,
   output tbts_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_RD, S_LATCH, S_MUL, S_ACC, S_FIN, S_ORD, S_OLAT,
      S_SQ, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_DONE, S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic [1:0] c_ff, c_in;
   logic [4:0] it_ff, it_in;
   logic       valid_ff, valid_in;

   logic emit_ok;
   assign emit_ok = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      c_in     = c_ff;
      it_in    = it_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      cmd.row  = k_ff;
      cmd.comp = c_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_in = 1'b1;
               k_in = 2'd0;
               c_in = 2'd0;
               if (req_op == OP_FIRST || req_op == OP_SECOND) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            cmd.mem_we = (status.op == OP_LOAD);
            state_in = S_IDLE;
         end
         S_RD: begin
            cmd.mem_re = 1'b1;
            state_in = S_LATCH;
         end
         S_LATCH: begin
            cmd.row_latch = 1'b1;
            c_in = 2'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (c_ff == 2'd2) begin
               c_in = 2'd0;
               if (k_ff == 2'd2) begin
                  state_in = S_FIN;
               end else begin
                  k_in = k_ff + 2'd1;
                  state_in = S_RD;
               end
            end else begin
               c_in = c_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            cmd.fin = 1'b1;
            state_in = (status.op == OP_SECOND) ? S_ORD : S_IDLE;
         end
         S_ORD: begin
            cmd.mem_re = 1'b1;
            cmd.row = ROW_ORIGIN;
            state_in = S_OLAT;
         end
         S_OLAT: begin
            cmd.org_latch = 1'b1;
            c_in = 2'd0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.sq = 1'b1;
            if (c_ff == 2'd2) begin
               c_in = 2'd0;
               state_in = S_SQRT_INIT;
            end else begin
               c_in = c_ff + 2'd1;
            end
         end
         S_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            it_in = 5'd0;
            state_in = status.len_zero ? S_EMIT : S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            it_in = it_ff + 5'd1;
            if (it_ff == 5'd31) begin
               c_in = 2'd0;
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            it_in = 5'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            it_in = it_ff + 5'd1;
            if (it_ff == 5'd15) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            cmd.div_done = 1'b1;
            if (c_ff == 2'd2) begin
               state_in = S_EMIT;
            end else begin
               c_in = c_ff + 2'd1;
               state_in = S_DIV_INIT;
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               cmd.out_load = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= 2'd0;
         c_ff     <= 2'd0;
         it_ff    <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         c_ff     <= c_in;
         it_ff    <= it_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule

// ----- src/tbts_dp.sv -----
// Datapath of the skinning block: frame memory, multiply-accumulate, square root, divider.
`timescale 1ns / 1ps

module tbts_dp
   import tbts_pkg::*;
#(
   parameter int unsigned MAX_SEGMENTS = 64
)
(
   input  logic               clock,
   input  logic               reset,
   input  tbts_item_type      item,
   input  tbts_cmd_type       cmd,
   output tbts_status_type    status,
   output logic [RSP_W-1:0]   rsp_data
);

   localparam int unsigned DEPTH = MAX_SEGMENTS * 4;
   localparam int unsigned AW    = $clog2(DEPTH);

   logic [ROW_W-1:0] mem [DEPTH];
   logic [ROW_W-1:0] rd_ff;

   logic [1:0]              op_ff;
   logic [5:0]              seg_ff;
   logic [1:0]              row_ff;
   logic signed [POS_W-1:0] a_ff    [3];
   logic signed [NRM_W-1:0] b_ff    [3];
   logic signed [POS_W-1:0] frow_ff [3];
   logic signed [47:0]      pprod_ff;
   logic signed [39:0]      nprod_ff;
   logic signed [49:0]      psum_ff [3];
   logic signed [41:0]      nsum_ff [3];
   logic signed [25:0]      pacc_ff [3];
   logic signed [17:0]      nacc_ff [3];
   logic signed [POS_W-1:0] pos_ff  [3];
   logic signed [NRM_W-1:0] nrm_ff  [3];
   logic [35:0]             len2_ff;
   logic [63:0]             x_ff, r_ff, bit_ff;
   logic [47:0]             rem_ff, d_ff;
   logic [15:0]             q_ff;
   logic                    neg_ff;
   logic [RSP_W-1:0]        out_ff;

   logic           seg_ok;
   logic [1:0]     row_sel;
   logic [AW-1:0]  addr;
   logic [63:0]    sq_t;
   logic signed [35:0] sq_v;
   logic [17:0]    mag;
   logic [15:0]    u;

   function automatic logic signed [25:0] pacc_next(input logic signed [25:0] base,
                                                    input logic signed [49:0] s);
      logic signed [49:0] t;
      logic signed [35:0] v;
      t = s + 50'sd16384;
      v = 36'(base) + 36'($signed(t[49:15]));
      if (v > 36'sd33554431) begin
         return 26'sd33554431;
      end else if (v < -36'sd33554432) begin
         return -26'sd33554432;
      end
      return v[25:0];
   endfunction

   function automatic logic signed [17:0] nacc_next(input logic signed [17:0] base,
                                                    input logic signed [41:0] s);
      logic signed [41:0] t;
      logic signed [27:0] v;
      t = s + 42'sd16384;
      v = 28'(base) + 28'($signed(t[41:15]));
      if (v > 28'sd131071) begin
         return 18'sd131071;
      end else if (v < -28'sd131072) begin
         return -18'sd131072;
      end
      return v[17:0];
   endfunction

   function automatic logic signed [23:0] pos_sat(input logic signed [25:0] acc,
                                                  input logic signed [23:0] org);
      logic signed [26:0] v;
      v = 27'(acc) + 27'(org);
      if (v > 27'sd8388607) begin
         return 24'sd8388607;
      end else if (v < -27'sd8388608) begin
         return -24'sd8388608;
      end
      return v[23:0];
   endfunction

   assign seg_ok  = (32'(seg_ff) < MAX_SEGMENTS);
   assign row_sel = cmd.mem_we ? row_ff : cmd.row;
   assign addr    = AW'(32'(seg_ff) * 32'd4 + 32'(row_sel));
   assign sq_t    = r_ff + bit_ff;
   assign sq_v    = nacc_ff[cmd.comp] * nacc_ff[cmd.comp];
   assign mag     = nacc_ff[cmd.comp][17] ? 18'(-nacc_ff[cmd.comp]) : 18'(nacc_ff[cmd.comp]);
   assign u       = (q_ff > 16'd16384) ? 16'd16384 : q_ff;

   // Frame memory: one 72-bit row per write, registered read.
   always_ff @(posedge clock) begin
      if (cmd.mem_we && seg_ok) begin
         mem[addr] <= {a_ff[2], a_ff[1], a_ff[0]};
      end
      if (cmd.mem_re) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         op_ff   <= item.operation;
         seg_ff  <= item.segment;
         row_ff  <= item.row;
         a_ff[0] <= item.a_x;
         a_ff[1] <= item.a_y;
         a_ff[2] <= item.a_z;
         b_ff[0] <= item.b_x;
         b_ff[1] <= item.b_y;
         b_ff[2] <= item.b_z;
         for (int c = 0; c < 3; c++) begin
            psum_ff[c] <= '0;
            nsum_ff[c] <= '0;
         end
      end
      if (cmd.row_latch) begin
         for (int c = 0; c < 3; c++) begin
            frow_ff[c] <= seg_ok ? $signed(rd_ff[c*POS_W +: POS_W]) : '0;
         end
      end
      if (cmd.mul) begin
         pprod_ff <= a_ff[cmd.row] * frow_ff[cmd.comp];
         nprod_ff <= 40'(b_ff[cmd.row]) * 40'(frow_ff[cmd.comp]);
      end
      if (cmd.acc) begin
         psum_ff[cmd.comp] <= psum_ff[cmd.comp] + 50'(pprod_ff);
         nsum_ff[cmd.comp] <= nsum_ff[cmd.comp] + 42'(nprod_ff);
      end
      if (cmd.org_latch) begin
         for (int c = 0; c < 3; c++) begin
            pos_ff[c] <= pos_sat(pacc_ff[c],
                                 seg_ok ? $signed(rd_ff[c*POS_W +: POS_W]) : 24'sd0);
         end
         len2_ff <= '0;
      end
      if (cmd.sq) begin
         len2_ff <= len2_ff + $unsigned(sq_v);
      end
      if (cmd.sqrt_init) begin
         x_ff   <= {len2_ff, 28'b0};
         r_ff   <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end
      if (cmd.sqrt_step) begin
         if (x_ff >= sq_t) begin
            x_ff <= x_ff - sq_t;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.div_init) begin
         rem_ff <= {2'b0, mag, 28'b0} + {17'b0, r_ff[31:1]};
         d_ff   <= {1'b0, r_ff[31:0], 15'b0};
         q_ff   <= '0;
         neg_ff <= nacc_ff[cmd.comp][17];
      end
      if (cmd.div_step) begin
         if (rem_ff >= d_ff) begin
            rem_ff <= rem_ff - d_ff;
            q_ff   <= {q_ff[14:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[14:0], 1'b0};
         end
         d_ff <= d_ff >> 1;
      end
      if (cmd.div_done) begin
         nrm_ff[cmd.comp] <= neg_ff ? $signed(-u) : $signed(u);
      end
      if (cmd.out_load) begin
         if (len2_ff == '0) begin
            out_ff <= {48'b0, pos_ff[2], pos_ff[1], pos_ff[0]};
         end else begin
            out_ff <= {nrm_ff[2], nrm_ff[1], nrm_ff[0], pos_ff[2], pos_ff[1], pos_ff[0]};
         end
      end
   end

   // Accumulators carry a defined reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            pacc_ff[c] <= '0;
            nacc_ff[c] <= '0;
         end
      end else if (cmd.fin) begin
         for (int c = 0; c < 3; c++) begin
            pacc_ff[c] <= pacc_next((op_ff == OP_FIRST) ? 26'sd0 : pacc_ff[c], psum_ff[c]);
            nacc_ff[c] <= nacc_next((op_ff == OP_FIRST) ? 18'sd0 : nacc_ff[c], nsum_ff[c]);
         end
      end else if (cmd.out_load) begin
         for (int c = 0; c < 3; c++) begin
            pacc_ff[c] <= '0;
            nacc_ff[c] <= '0;
         end
      end
   end

   assign status.op       = op_ff;
   assign status.len_zero = (len2_ff == '0);
   assign rsp_data        = out_ff;

endmodule

// ----- src/two_bone_tube_skinning.sv -----
// Top level of the two-bone tube skinning block.
`timescale 1ns / 1ps

// Linear blend skinning of tube vertices over two segment frames with equal
// weights. Load beats fill the frame memory one 72-bit row at a time (three
// axis rows in Q2.14 and one origin row in Q12 per segment). A first-bone
// beat restarts the vertex with half of its frame-weighted position and
// normal; a second-bone beat adds its half, adds the origin of its segment and
// emits one vertex with a unit normal. One beat is worked at a time. A load
// writes its row in the write state, and an ignored operation code passes
// through that state without a write. A first-bone beat reads three frame
// rows, and each row feeds three multiply and accumulate steps through one
// shared pair of multipliers. A second-bone beat does the same, then the
// origin read and the squared length, a setup step and a 32-step square
// root, and for each normal component a 16-step divider with one setup and
// one finish step, and then loads the output register; with a zero normal
// the root and divider are skipped. A finished vertex sits in the output
// register while the next beat is taken; the block stalls only if a second
// vertex is ready before the first one has left.
module two_bone_tube_skinning
   import tbts_pkg::*;
#(
   parameter int unsigned MAX_SEGMENTS = 64
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // segment[5:0], row[7:6], a_x[31:8], a_y[55:32], a_z[79:56],
   // b_x[95:80], b_y[111:96], b_z[127:112]
   input  logic [REQ_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pos_x[23:0], pos_y[47:24], pos_z[71:48],
   // norm_x[87:72], norm_y[103:88], norm_z[119:104]
   output logic [RSP_W-1:0] rsp_tdata
);

   tbts_item_type   item;
   tbts_cmd_type    cmd;
   tbts_status_type status;

   // Unpack the request beat.
   assign item.operation = req_tuser;
   assign item.segment   = req_tdata[5:0];
   assign item.row       = req_tdata[7:6];
   assign item.a_x       = req_tdata[31:8];
   assign item.a_y       = req_tdata[55:32];
   assign item.a_z       = req_tdata[79:56];
   assign item.b_x       = req_tdata[95:80];
   assign item.b_y       = req_tdata[111:96];
   assign item.b_z       = req_tdata[127:112];

   tbts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tbts_dp #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_tdata)
   );

endmodule

// ----- src/tbts_checker.sv -----
// Port-level assertions of the skinning block and their binding to the top level.
`timescale 1ns / 1ps

module tbts_checker
   import tbts_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic [1:0]       req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A stalled result beat keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // No result survives reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Every accepted beat leaves the block busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // Normal components stay within the unit range.
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[87:72]) <= 16'sd16384 && $signed(rsp_tdata[87:72]) >= -16'sd16384 &&
         $signed(rsp_tdata[103:88]) <= 16'sd16384 && $signed(rsp_tdata[103:88]) >= -16'sd16384 &&
         $signed(rsp_tdata[119:104]) <= 16'sd16384 && $signed(rsp_tdata[119:104]) >= -16'sd16384)
      else $error("normal component out of range");

endmodule

bind two_bone_tube_skinning tbts_checker u_tbts_checker (.*);
